FILE: design/gpb_pkg.sv
package gpb_pkg;

    localparam int NUM_REGS = 11;

    typedef enum logic [1:0] {
        OP_READ    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_DRIVE   = 2'd2,
        OP_RELEASE = 2'd3
    } gpb_op_t;

    localparam logic [3:0] IDX_MODER = 4'd0;
    localparam logic [3:0] IDX_PUPDR = 4'd3;
    localparam logic [3:0] IDX_IDR   = 4'd4;
    localparam logic [3:0] IDX_ODR   = 4'd5;
    localparam logic [3:0] IDX_BSRR  = 4'd6;
    localparam logic [3:0] IDX_BRR   = 4'd10;
    localparam logic [3:0] IDX_LAST  = 4'(NUM_REGS - 1);

    localparam logic [1:0] MODE_INPUT  = 2'd0;
    localparam logic [1:0] MODE_OUTPUT = 2'd1;
    localparam logic [1:0] MODE_ALT    = 2'd2;
    localparam logic [1:0] PULL_UP     = 2'd1;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  reg_index;
        logic [31:0] write_data;
        logic [31:0] wr_mask;
        logic [3:0]  pin;
        logic        level;
    } gpb_req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [15:0] out_pins;
        logic [15:0] out_changed;
        logic [15:0] in_pins;
        logic [15:0] in_changed;
    } gpb_rsp_t;

    // A driven pin follows its external source; otherwise output and alternate
    // modes reflect ODR and an input with pull-up reads high.
    function automatic logic [15:0] gpb_input_levels(
        input logic [31:0] moder,
        input logic [31:0] pupdr,
        input logic [15:0] odr,
        input logic [15:0] dmask,
        input logic [15:0] dlev
    );
        logic [15:0] lev;
        logic [1:0]  mode;
        logic [1:0]  pull;
        for (int i = 0; i < 16; i++)
        begin
            mode = moder[2*i +: 2];
            pull = pupdr[2*i +: 2];
            if (dmask[i])
            begin
                lev[i] = dlev[i];
            end
            else
            begin
                lev[i] = ((mode == MODE_OUTPUT || mode == MODE_ALT) && odr[i])
                      || (mode == MODE_INPUT && pull == PULL_UP);
            end
        end
        return lev;
    endfunction

endpackage

FILE: design/gpb_core.sv
module gpb_core #(
    parameter int NUM_PINS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  gpb_pkg::gpb_req_t req,
    output gpb_pkg::gpb_rsp_t result
);
    import gpb_pkg::*;

    localparam logic [15:0] PinMask = 16'((32'd1 << NUM_PINS) - 32'd1);

    logic [31:0] regs_reg  [NUM_REGS];
    logic [31:0] regs_next [NUM_REGS];
    logic [15:0] dmask_reg;
    logic [15:0] dmask_next;
    logic [15:0] dlev_reg;
    logic [15:0] dlev_next;

    logic [15:0] odr_cur;
    logic [15:0] odr_new;
    logic [15:0] lev_cur;
    logic [15:0] lev_new;
    logic [31:0] cmd;
    logic [31:0] rdata;
    logic [15:0] pin_bit;
    logic        pin_ok;
    logic        pin_op;

    assign odr_cur = regs_reg[IDX_ODR][15:0] & PinMask;
    assign cmd     = req.write_data & req.wr_mask;
    assign pin_bit = 16'd1 << req.pin;
    assign pin_ok  = {1'b0, req.pin} < 5'(NUM_PINS);
    assign pin_op  = (req.opcode == OP_DRIVE || req.opcode == OP_RELEASE) && pin_ok;

    assign lev_cur = gpb_input_levels(regs_reg[IDX_MODER], regs_reg[IDX_PUPDR], odr_cur,
                                      dmask_reg, dlev_reg) & PinMask;

    always_comb
    begin
        regs_next  = regs_reg;
        dmask_next = dmask_reg;
        dlev_next  = dlev_reg;
        rdata      = '0;
        unique case (req.opcode)
            OP_READ:
            begin
                if (req.reg_index == IDX_IDR)
                begin
                    rdata              = {16'd0, lev_cur};
                    regs_next[IDX_IDR] = {16'd0, lev_cur};
                end
                else if (req.reg_index != IDX_BSRR && req.reg_index != IDX_BRR
                         && req.reg_index <= IDX_LAST)
                begin
                    rdata = regs_reg[req.reg_index];
                end
            end
            OP_WRITE:
            begin
                if (req.reg_index == IDX_BSRR)
                begin
                    regs_next[IDX_ODR] = {16'd0, ((odr_cur & ~cmd[31:16]) | cmd[15:0])
                                                 & PinMask};
                end
                else if (req.reg_index == IDX_BRR)
                begin
                    regs_next[IDX_ODR] = {16'd0, odr_cur & ~cmd[15:0] & PinMask};
                end
                else if (req.reg_index == IDX_ODR)
                begin
                    regs_next[IDX_ODR] = ((regs_reg[IDX_ODR] & ~req.wr_mask) | cmd)
                                         & {16'd0, PinMask};
                end
                else if (req.reg_index != IDX_IDR && req.reg_index <= IDX_LAST)
                begin
                    regs_next[req.reg_index] = (regs_reg[req.reg_index] & ~req.wr_mask)
                                               | cmd;
                end
            end
            OP_DRIVE:
            begin
                if (pin_ok)
                begin
                    dmask_next = dmask_reg | pin_bit;
                    dlev_next  = req.level ? (dlev_reg | pin_bit) : (dlev_reg & ~pin_bit);
                end
            end
            OP_RELEASE:
            begin
                if (pin_ok)
                begin
                    dmask_next = dmask_reg & ~pin_bit;
                end
            end
            default:
            begin
                rdata = '0;
            end
        endcase
    end

    assign odr_new = regs_next[IDX_ODR][15:0] & PinMask;
    assign lev_new = gpb_input_levels(regs_next[IDX_MODER], regs_next[IDX_PUPDR], odr_new,
                                      dmask_next, dlev_next) & PinMask;

    assign result.read_data   = rdata;
    assign result.out_pins    = odr_new;
    assign result.out_changed = odr_cur ^ odr_new;
    assign result.in_pins     = lev_new;
    assign result.in_changed  = pin_op ? ((lev_cur ^ lev_new) & pin_bit) : 16'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                regs_reg[i] <= (4'(i) == IDX_MODER) ? 32'hffff_ffff : 32'd0;
            end
            dmask_reg <= '0;
            dlev_reg  <= '0;
        end
        else if (fire)
        begin
            regs_reg  <= regs_next;
            dmask_reg <= dmask_next;
            dlev_reg  <= dlev_next;
        end
    end

    a_odr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (regs_reg[IDX_ODR] & ~{16'd0, PinMask}) == 32'd0)
        else $error("ODR holds bits beyond the pin count.");

    a_dmask_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (dmask_reg & ~PinMask) == 16'd0)
        else $error("A pin beyond the pin count is marked as driven.");

    a_set_reset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        regs_reg[IDX_BSRR] == 32'd0 && regs_reg[IDX_BRR] == 32'd0)
        else $error("BSRR or BRR holds a nonzero value.");

    a_idr_write_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        fire && req.opcode == OP_WRITE && req.reg_index == IDX_IDR
        |=> $stable(regs_reg[IDX_IDR]))
        else $error("A write changed IDR.");

endmodule

FILE: design/gpio_port_register_block_unit.sv
// GPIO port register block: one transaction on req is a bus read, a masked bus write, an
// external drive of one pin or its release, and each gives exactly one rsp transaction with
// read data, output levels, input levels and the pins that changed. The block accepts a
// transaction every cycle while rsp is not stalled; each one waits in the input register,
// where the whole register file update and pin evaluation happen, and then in the output
// register, from which the result on rsp can be taken when rsp is not stalled. State resets
// to MODER all ones, every other register zero, and no pin driven.
module gpio_port_register_block_unit #(
    parameter int NUM_PINS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  gpb_pkg::gpb_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output gpb_pkg::gpb_rsp_t rsp
);
    import gpb_pkg::*;

    logic     req_valid_reg;
    gpb_req_t req_reg;
    logic     rsp_valid_reg;
    gpb_rsp_t rsp_reg;
    gpb_rsp_t result;
    logic     advance;
    logic     fire;

    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign fire      = req_valid_reg && advance;
    assign req_stall = req_valid_reg && !advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    gpb_core #(
        .NUM_PINS (NUM_PINS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .req    (req_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (!req_stall)
            begin
                req_valid_reg <= req_valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= req_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            req_reg <= req;
        end
        if (fire)
        begin
            rsp_reg <= result;
        end
    end

    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid_reg && rsp_valid_reg && rsp_stall |-> req_stall)
        else $error("Input taken while both stages are full and the output is stalled.");

    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> rsp_valid)
        else $error("A processed transaction produced no result.");

endmodule
